// ----- src/rrr_pkg.sv -----
// Shared constants, codes and controller/datapath interface types of the ready ring.
package rrr_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int FUNC_W    = 2;
	localparam int ID_W      = 4;
	localparam int STATUS_W  = 2;
	localparam int LEN_W     = 5;

	localparam logic [FUNC_W-1:0] FUNC_ADMIT  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_NEXT   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

	typedef enum logic [1:0] {RD_ID, RD_HEAD, RD_DATA} rd_sel_t;
	typedef enum logic [2:0] {WR_NONE, WR_SELF, WR_TAIL_LINK, WR_NEW_LINK, WR_UNLINK} wr_op_t;
	typedef enum logic [1:0] {UPD_NONE, UPD_ADMIT, UPD_EMPTY, UPD_REMOVE} upd_op_t;

	typedef struct packed {
		logic                item_load;
		logic                rd_en;
		rd_sel_t             rd_sel;
		wr_op_t              wr_op;
		upd_op_t             upd_op;
		logic                pred_head;
		logic                pred_next;
		logic                succ_load;
		logic                out_load;
		logic [STATUS_W-1:0] res_status;
		logic                res_next;
	} rrr_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              id_ok;
		logic              member;
		logic              full;
		logic              empty;
		logic              single;
		logic              hit;
	} rrr_sts_t;

endpackage

// ----- src/rrr_dpath.sv -----
// Datapath: successor memory, ring registers, item and result registers.
module rrr_dpath import rrr_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [FUNC_W-1:0]   func,
	input  logic [ID_W-1:0]     thread_id,
	input  rrr_cmd_t            cmd,
	output rrr_sts_t            sts,
	output logic [ID_W-1:0]     next_id,
	output logic                has_next,
	output logic [STATUS_W-1:0] status,
	output logic [LEN_W-1:0]    ring_length
);

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);

	logic [SLOT_W-1:0] succ_mem [SLOTS];

	logic [FUNC_W-1:0] func_q;
	logic [ID_W-1:0]   id_q;
	logic [SLOT_W-1:0] rd_q;
	logic [SLOT_W-1:0] pred_q;
	logic [SLOT_W-1:0] succ_q;
	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [SLOTS-1:0]  member_q;

	logic [SLOT_W-1:0] id_slot;
	logic [SLOT_W-1:0] rd_addr;
	logic [SLOT_W-1:0] wr_addr;
	logic [SLOT_W-1:0] wr_data;
	logic              id_ok;

	assign id_slot = SLOT_W'(id_q);
	assign id_ok   = (32'(id_q) < 32'(SLOTS));

	assign sts.func   = func_q;
	assign sts.id_ok  = id_ok;
	assign sts.member = id_ok && member_q[id_slot];
	assign sts.full   = (32'(count_q) >= 32'(SLOTS));
	assign sts.empty  = (count_q == '0);
	assign sts.single = (count_q <= CNT_W'(1));
	assign sts.hit    = (rd_q == id_slot);

	always_comb begin
		case (cmd.rd_sel)
			RD_ID:   rd_addr = id_slot;
			RD_HEAD: rd_addr = head_q;
			RD_DATA: rd_addr = rd_q;
			default: rd_addr = id_slot;
		endcase
	end

	always_comb begin
		case (cmd.wr_op)
			WR_SELF: begin
				wr_addr = id_slot;
				wr_data = id_slot;
			end
			WR_TAIL_LINK: begin
				wr_addr = tail_q;
				wr_data = id_slot;
			end
			WR_NEW_LINK: begin
				wr_addr = id_slot;
				wr_data = head_q;
			end
			WR_UNLINK: begin
				wr_addr = pred_q;
				wr_data = succ_q;
			end
			default: begin
				wr_addr = id_slot;
				wr_data = id_slot;
			end
		endcase
	end

	// successor memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_op != WR_NONE) begin
			succ_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= succ_mem[rd_addr];
		end
	end

	// item, walk and result registers
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			func_q <= func;
			id_q   <= thread_id;
		end
		if (cmd.succ_load) begin
			succ_q <= rd_q;
		end
		if (cmd.pred_head) begin
			pred_q <= head_q;
		end else if (cmd.pred_next) begin
			pred_q <= rd_q;
		end
		if (cmd.out_load) begin
			next_id     <= cmd.res_next ? ID_W'(rd_q) : '0;
			has_next    <= cmd.res_next;
			status      <= cmd.res_status;
			ring_length <= LEN_W'(count_q);
		end
	end

	// ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			member_q <= '0;
		end else begin
			case (cmd.upd_op)
				UPD_ADMIT: begin
					member_q[id_slot] <= 1'b1;
					tail_q            <= id_slot;
					count_q           <= count_q + CNT_W'(1);
					if (count_q == '0) begin
						head_q <= id_slot;
					end
				end
				UPD_EMPTY: begin
					member_q[id_slot] <= 1'b0;
					count_q           <= '0;
					head_q            <= '0;
					tail_q            <= '0;
				end
				UPD_REMOVE: begin
					member_q[id_slot] <= 1'b0;
					count_q           <= count_q - CNT_W'(1);
					if (head_q == id_slot) begin
						head_q <= succ_q;
					end
					if (tail_q == id_slot) begin
						tail_q <= pred_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- src/rrr_ctrl.sv -----
// Controller: sequences admit, remove walk and next lookup, owns the handshakes.
module rrr_ctrl import rrr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  rrr_sts_t sts,
	output rrr_cmd_t cmd
);

	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_ADM2, S_RM_SUCC, S_WALK, S_NXT, S_FINISH} state_t;

	state_t              state_q, state_d;
	logic [STATUS_W-1:0] res_st_q, res_st_d;
	logic                res_nxt_q, res_nxt_d;
	logic                out_valid_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		res_st_d    = res_st_q;
		res_nxt_d   = res_nxt_q;
		out_valid_d = out_valid && !out_ready;

		cmd            = '0;
		cmd.rd_sel     = RD_ID;
		cmd.wr_op      = WR_NONE;
		cmd.upd_op     = UPD_NONE;
		cmd.res_status = res_st_q;
		cmd.res_next   = res_nxt_q;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.item_load = 1'b1;
					state_d       = S_CHECK;
				end
			end
			S_CHECK: begin
				res_st_d  = ST_OK;
				res_nxt_d = 1'b0;
				state_d   = S_FINISH;
				case (sts.func)
					FUNC_ADMIT: begin
						if (!sts.id_ok || sts.member || sts.full) begin
							res_st_d = ST_REJECT;
						end else if (sts.empty) begin
							cmd.wr_op  = WR_SELF;
							cmd.upd_op = UPD_ADMIT;
						end else begin
							cmd.wr_op = WR_TAIL_LINK;
							state_d   = S_ADM2;
						end
					end
					FUNC_REMOVE: begin
						if (!sts.member) begin
							res_st_d = ST_ABSENT;
						end else if (sts.single) begin
							cmd.upd_op = UPD_EMPTY;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_ID;
							state_d    = S_RM_SUCC;
						end
					end
					FUNC_NEXT: begin
						if (!sts.member) begin
							res_st_d = ST_ABSENT;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_ID;
							state_d    = S_NXT;
						end
					end
					default: begin
					end
				endcase
			end
			S_ADM2: begin
				cmd.wr_op  = WR_NEW_LINK;
				cmd.upd_op = UPD_ADMIT;
				state_d    = S_FINISH;
			end
			S_RM_SUCC: begin
				cmd.succ_load = 1'b1;
				cmd.pred_head = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = RD_HEAD;
				state_d       = S_WALK;
			end
			S_WALK: begin
				if (sts.hit) begin
					cmd.wr_op  = WR_UNLINK;
					cmd.upd_op = UPD_REMOVE;
					state_d    = S_FINISH;
				end else begin
					cmd.pred_next = 1'b1;
					cmd.rd_en     = 1'b1;
					cmd.rd_sel    = RD_DATA;
				end
			end
			S_NXT: begin
				res_nxt_d = !sts.hit;
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			res_st_q  <= ST_OK;
			res_nxt_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_st_q  <= res_st_d;
			res_nxt_q <= res_nxt_d;
			out_valid <= out_valid_d;
		end
	end

endmodule

// ----- src/round_robin_ready_ring_core.sv -----
// Top level of the round-robin ready ring: controller plus datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid / in_ready  | func, thread_id
//   output  | out_valid / out_ready| next_id, has_next, status, ring_length
//
// One item is in work at a time. Rejects, unknown codes, empty-ring admits and
// last-member removes go from check to finish; other admits add a link write,
// a next adds a successor read, and other removes read the successor, then walk
// from the head to the predecessor (up to ring length - 1 entries).
// The walk reads the successor memory one entry a cycle; that read port sets
// the remove time. A finished result sits in the output register, so a
// new item is taken while it waits; a stalled output only holds the next
// result back. Reset clears head, tail, count and membership; the successor
// memory needs no clearing, as entries are read only for members.
module round_robin_ready_ring_core import rrr_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [FUNC_W-1:0]   func,
	input  logic [ID_W-1:0]     thread_id,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ID_W-1:0]     next_id,
	output logic                has_next,
	output logic [STATUS_W-1:0] status,
	output logic [LEN_W-1:0]    ring_length
);

	rrr_cmd_t cmd;
	rrr_sts_t sts;

	// sequencing and handshakes
	rrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// ring storage and result register
	rrr_dpath #(
		.SLOTS (SLOTS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.func        (func),
		.thread_id   (thread_id),
		.cmd         (cmd),
		.sts         (sts),
		.next_id     (next_id),
		.has_next    (has_next),
		.status      (status),
		.ring_length (ring_length)
	);

endmodule

// ----- sim/round_robin_ready_ring_core_tb.sv -----
// Testbench for the round-robin ready ring: directed and random traffic checked against a ring predictor.
module round_robin_ready_ring_core_tb;
	import rrr_pkg::*;

	localparam int                NSLOT       = SLOTS_DEF;
	localparam logic [FUNC_W-1:0] FUNC_IDLE   = 2'd3;	// unused code, no operation
	localparam int                RAND_OPS    = 2000;
	localparam int                HOLD_AFTER  = 500;	// items taken before the long output hold
	localparam int                HOLD_CYCLES = 300;
	localparam int                DRAIN_WAIT  = 40;	// beyond the longest remove walk

	typedef struct packed {
		logic [FUNC_W-1:0] fn;
		logic [ID_W-1:0]   id;
	} ring_op_t;

	typedef struct packed {
		logic [ID_W-1:0]     nid;
		logic                has;
		logic [STATUS_W-1:0] st;
		logic [LEN_W-1:0]    len;
	} ring_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [FUNC_W-1:0]   func = '0;
	logic [ID_W-1:0]     thread_id = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [ID_W-1:0]     next_id;
	logic                has_next;
	logic [STATUS_W-1:0] status;
	logic [LEN_W-1:0]    ring_length;

	round_robin_ready_ring_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.thread_id  (thread_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.next_id    (next_id),
		.has_next   (has_next),
		.status     (status),
		.ring_length(ring_length)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// predictor copy of the ring
	logic [ID_W-1:0]  ring_succ [NSLOT];
	logic [NSLOT-1:0] ring_member;
	logic [ID_W-1:0]  ring_head;
	logic [ID_W-1:0]  ring_tail;
	logic [LEN_W-1:0] ring_count;

	ring_op_t     ops_pending[$];
	ring_result_t ring_results_due[$];

	int errors;
	int items_taken;
	int results_seen;
	int per_func[4];
	int peak_len;
	int full_rejects;
	int hold_left;
	bit hold_done;
	int hold_stall_cycles;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	// work out the result of one item and advance the ring
	task automatic ring_apply(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id);
		ring_result_t r;
		logic [ID_W-1:0] pred;
		r = '0;
		r.st = ST_OK;
		case (fn)
			FUNC_ADMIT: begin
				if (ring_member[id] || ring_count >= NSLOT) begin
					r.st = ST_REJECT;
				end else begin
					if (ring_count == 0) begin
						ring_head = id;
						ring_succ[id] = id;
					end else begin
						ring_succ[ring_tail] = id;
						ring_succ[id] = ring_head;
					end
					ring_tail = id;
					ring_member[id] = 1'b1;
					ring_count++;
				end
			end
			FUNC_REMOVE: begin
				if (!ring_member[id]) begin
					r.st = ST_ABSENT;
				end else begin
					ring_member[id] = 1'b0;
					if (ring_count <= 1) begin
						ring_count = 0;
						ring_head = '0;
						ring_tail = '0;
					end else begin
						// find the slot that points at the one leaving
						pred = ring_head;
						for (int k = 0; k < NSLOT; k++) begin
							if (ring_succ[pred] == id) break;
							pred = ring_succ[pred];
						end
						ring_succ[pred] = ring_succ[id];
						if (ring_head == id) ring_head = ring_succ[id];
						if (ring_tail == id) ring_tail = pred;
						ring_count--;
					end
				end
			end
			FUNC_NEXT: begin
				if (!ring_member[id]) begin
					r.st = ST_ABSENT;
				end else if (ring_succ[id] != id) begin
					r.nid = ring_succ[id];
					r.has = 1'b1;
				end
			end
			default: ;
		endcase
		r.len = ring_count;
		if (fn == FUNC_ADMIT && r.st == ST_REJECT && ring_count == NSLOT) full_rejects++;
		if (ring_count > peak_len) peak_len = ring_count;
		ring_results_due.push_back(r);
	endtask

	// mostly short gaps, a few long ones, none during a burst
	function automatic int pick_gap(input bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// driver
	int  send_gap;
	bit  send_burst;
	ring_op_t next_op;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			func       <= '0;
			thread_id  <= '0;
			send_gap   <= 0;
			send_burst <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				ring_apply(func, thread_id);
				per_func[func]++;
				items_taken++;
				if ($urandom_range(0, 99) < 2) send_burst <= ~send_burst;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (ops_pending.size() > 0) begin
					next_op   = ops_pending.pop_front();
					in_valid  <= 1'b1;
					func      <= next_op.fn;
					thread_id <= next_op.id;
					send_gap  <= pick_gap(send_burst);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	ring_result_t want;

	always @(posedge clk or negedge arst_n) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (ring_results_due.size() == 0) begin
				report_mismatch($sformatf(
					"unexpected result next_id=%0d has_next=%0d status=%0d len=%0d",
					next_id, has_next, status, ring_length));
			end else begin
				want = ring_results_due.pop_front();
				if (next_id !== want.nid)
					report_mismatch($sformatf("next_id %0d, expected %0d",
						next_id, want.nid));
				if (has_next !== want.has)
					report_mismatch($sformatf("has_next %0d, expected %0d",
						has_next, want.has));
				if (status !== want.st)
					report_mismatch($sformatf("status %0d, expected %0d",
						status, want.st));
				if (ring_length !== want.len)
					report_mismatch($sformatf("ring_length %0d, expected %0d",
						ring_length, want.len));
			end
		end
	end

	// receiver readiness
	int  recv_gap;
	bit  recv_burst;
	int  g;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			recv_gap   <= 0;
			recv_burst <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			out_ready <= 1'b0;
			recv_gap  <= recv_gap - 1;
		end else if (out_valid && out_ready) begin
			if ($urandom_range(0, 99) < 2) recv_burst <= ~recv_burst;
			g = pick_gap(recv_burst);
			out_ready <= (g == 0);
			recv_gap  <= (g > 0) ? g - 1 : 0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// one long output hold, so the block backs up and refuses input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && items_taken >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			if (in_valid && !in_ready) hold_stall_cycles++;
		end
	end

	// stimulus generation, with its own view of membership for biasing
	logic [NSLOT-1:0] gen_member;
	int               gen_count;

	function automatic logic [ID_W-1:0] pick_member();
		int n;
		int k;
		if (gen_count == 0) return ID_W'($urandom_range(0, NSLOT - 1));
		n = $urandom_range(0, gen_count - 1);
		for (k = 0; k < NSLOT; k++) begin
			if (gen_member[k]) begin
				if (n == 0) return ID_W'(k);
				n--;
			end
		end
		return '0;
	endfunction

	function automatic logic [ID_W-1:0] pick_outsider();
		int k;
		if (gen_count >= NSLOT) return ID_W'($urandom_range(0, NSLOT - 1));
		k = $urandom_range(0, NSLOT - 1);
		while (gen_member[k]) k = (k + 1) % NSLOT;
		return ID_W'(k);
	endfunction

	task automatic queue_op(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id);
		ring_op_t op;
		op.fn = fn;
		op.id = id;
		ops_pending.push_back(op);
		if (fn == FUNC_ADMIT && !gen_member[id] && gen_count < NSLOT) begin
			gen_member[id] = 1'b1;
			gen_count++;
		end else if (fn == FUNC_REMOVE && gen_member[id]) begin
			gen_member[id] = 1'b0;
			gen_count--;
		end
	endtask

	initial begin
		int mode;
		int r;
		ring_member = '0;
		ring_head   = '0;
		ring_tail   = '0;
		ring_count  = '0;
		gen_member  = '0;
		gen_count   = 0;
		errors = 0;
		items_taken = 0;
		results_seen = 0;
		peak_len = 0;
		full_rejects = 0;
		hold_stall_cycles = 0;
		foreach (per_func[i]) per_func[i] = 0;

		// directed: empty ring, lone member, head/tail removal, wrap-around
		queue_op(FUNC_NEXT, 4'd5);	// absent on empty ring
		queue_op(FUNC_REMOVE, 4'd5);	// absent
		queue_op(FUNC_IDLE, 4'd15);	// unused code
		queue_op(FUNC_ADMIT, 4'd0);
		queue_op(FUNC_NEXT, 4'd0);	// lone member, no successor
		queue_op(FUNC_ADMIT, 4'd0);	// duplicate
		queue_op(FUNC_REMOVE, 4'd0);	// last member, ring empties
		queue_op(FUNC_ADMIT, 4'd15);
		queue_op(FUNC_ADMIT, 4'd3);
		queue_op(FUNC_ADMIT, 4'd9);
		queue_op(FUNC_NEXT, 4'd15);
		queue_op(FUNC_NEXT, 4'd9);	// tail wraps to head
		queue_op(FUNC_REMOVE, 4'd15);	// head leaves, tail relinked
		queue_op(FUNC_NEXT, 4'd9);
		queue_op(FUNC_ADMIT, 4'd15);
		queue_op(FUNC_REMOVE, 4'd15);	// tail leaves
		queue_op(FUNC_NEXT, 4'd3);
		queue_op(FUNC_REMOVE, 4'd9);
		queue_op(FUNC_NEXT, 4'd3);
		queue_op(FUNC_REMOVE, 4'd3);
		queue_op(FUNC_ADMIT, 4'd10);

		// random: phases that fill, drain or churn the ring, plus some noise
		mode = 0;
		for (int n = 0; n < RAND_OPS; n++) begin
			if (n % 60 == 0) mode = $urandom_range(0, 2);
			r = $urandom_range(0, 99);
			if (r < 6) begin
				queue_op(FUNC_W'($urandom_range(0, 3)), ID_W'($urandom_range(0, NSLOT - 1)));
			end else begin
				r = $urandom_range(0, 99);
				if ((mode == 0 && r < 65) || (mode == 1 && r < 15) || (mode == 2 && r < 35))
					queue_op(FUNC_ADMIT,
						($urandom_range(0, 9) < 8) ? pick_outsider() : pick_member());
				else if ((mode == 0 && r < 80) || (mode == 1 && r < 75) ||
						(mode == 2 && r < 65))
					queue_op(FUNC_REMOVE,
						($urandom_range(0, 9) < 9) ? pick_member() : pick_outsider());
				else
					queue_op(FUNC_NEXT,
						($urandom_range(0, 9) < 9) ? pick_member() : pick_outsider());
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (ops_pending.size() > 0 || in_valid) @(posedge clk);
		while (ring_results_due.size() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("ran %0d items (admit %0d, remove %0d, next %0d, unused code %0d)",
			items_taken, per_func[0], per_func[1], per_func[2], per_func[3]);
		$display("%0d results checked, ring peaked at %0d slots", results_seen, peak_len);
		$display("%0d admits refused on a full ring, input held off %0d cycles",
			full_rejects, hold_stall_cycles);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#10000000;
		$display("timeout with %0d results outstanding", ring_results_due.size());
		$display("status: fail");
		$finish;
	end

endmodule
